// ===== src/hpa_pkg.sv =====
// Shared types and constants for the harmonic phase accumulator.
`default_nettype none
package hpa_pkg;

    localparam int F0_W       = 18;  // f0 sample, unsigned Q10.8 Hz
    localparam int STEP_W     = 32;  // step_per_hz register
    localparam int OUT_W      = 32;  // output phase, turns * 2^32
    localparam int OUT_FIELDS = 9;   // phase fields on the result channel
    localparam int FRAC_W     = 48;  // harmonic step precision, 2^-48 turn
    localparam int PROD_W     = F0_W + STEP_W;

    // item queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // configuration registers
    localparam int          APB_AW          = 3;
    localparam int          APB_DW          = 32;
    localparam logic [0:0]  REG_STEP_PER_HZ = 1'b0;
    localparam logic [STEP_W-1:0] STEP_RESET = 32'd45812984;

    typedef struct packed {
        logic [F0_W-1:0] f0;
        logic            last;   // second sample of a frame
    } hpa_item_t;

endpackage
`default_nettype wire

// ===== src/hpa_front.sv =====
// Front end: accepts f0 samples, tags frame position, queues them for the back end.
`default_nettype none
module hpa_front
    import hpa_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [F0_W-1:0] s_f0_hz,
    output logic                 q_valid,
    input  wire logic            q_ready,
    output hpa_item_t            q_item
);

    hpa_item_t           queue_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                half_reg;
    logic                push, pop;

    assign s_ready = (cnt_reg < QCNT_W'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = queue_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            half_reg   <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
                half_reg   <= !half_reg;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= '{f0: s_f0_hz, last: half_reg};
        end
    end

    // queue never overfills
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("front queue count above depth");

    // frame position flips on every accepted sample
    a_half_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> (half_reg != $past(half_reg)))
        else $error("frame position did not advance");

    // count rises on a push without a pop
    a_cnt_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule
`default_nettype wire

// ===== src/hpa_back.sv =====
// Back end: step multiply, per-harmonic step lanes, accumulators and result register.
`default_nettype none
module hpa_back
    import hpa_pkg::*;
#(
    parameter int HARMONICS  = 9,
    parameter int PHASE_BITS = 32
)(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [STEP_W-1:0]     step_per_hz,
    input  wire logic                  q_valid,
    output logic                       q_ready,
    input  wire hpa_item_t             q_item,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [HARMONICS-1:0][OUT_W-1:0] m_phase
);

    logic                                 adv;
    logic [PROD_W-1:0]                    prod;

    logic                                 s1_valid_reg, s1_last_reg;
    logic [FRAC_W-1:0]                    s1_base_reg;
    logic                                 s2_valid_reg, s2_last_reg;
    logic [HARMONICS-1:0][PHASE_BITS-1:0] lane_step;
    logic [HARMONICS-1:0][PHASE_BITS-1:0] s2_step_reg;
    logic [HARMONICS-1:0][PHASE_BITS-1:0] acc_reg, acc_next;
    logic [HARMONICS-1:0][OUT_W-1:0]      phase_reg, phase_next;
    logic                                 m_valid_reg, m_valid_next;
    logic                                 commit;

    // whole pipeline holds while a finished result waits
    assign adv     = !m_valid_reg || m_ready;
    assign q_ready = adv;
    assign commit  = adv && s2_valid_reg;
    assign prod    = PROD_W'(q_item.f0) * PROD_W'(step_per_hz);

    assign m_valid = m_valid_reg;
    assign m_phase = phase_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit && s2_last_reg) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    for (genvar h = 0; h < HARMONICS; h++) begin : g_lane
        logic [FRAC_W-1:0] lane_mult;

        // (h+1) * base, wrapped to one turn, top PHASE_BITS kept
        assign lane_mult    = FRAC_W'(s1_base_reg * FRAC_W'(h + 1));
        assign lane_step[h] = lane_mult[FRAC_W-1 -: PHASE_BITS];
        assign acc_next[h]  = acc_reg[h] + s2_step_reg[h];

        if (PHASE_BITS >= OUT_W) begin : g_trunc
            assign phase_next[h] = acc_next[h][PHASE_BITS-1 -: OUT_W];
        end else begin : g_widen
            assign phase_next[h] = {acc_next[h], {(OUT_W-PHASE_BITS){1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            acc_reg      <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (adv) begin
                s1_valid_reg <= q_valid;
                s2_valid_reg <= s1_valid_reg;
            end
            if (commit) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_base_reg <= prod[FRAC_W-1:0];
            s1_last_reg <= q_item.last;
            s2_step_reg <= lane_step;
            s2_last_reg <= s1_last_reg;
        end
        if (commit && s2_last_reg) begin
            phase_reg <= phase_next;
        end
    end

    // a stalled result freezes the pipeline
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(s1_valid_reg) && $stable(s2_valid_reg)))
        else $error("pipeline moved while result stalled");

    // accumulators move only when an item completes
    a_acc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !commit |=> $stable(acc_reg))
        else $error("accumulator changed without an item");

    // a new result comes only from the second sample of a frame
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s2_valid_reg && s2_last_reg))
        else $error("result without a frame end");

endmodule
`default_nettype wire

// ===== src/harmonic_phase_accumulator.sv =====
// Top level of the harmonic phase accumulator: config register, front and back ends.
//
// Usage:
//  - s_ channel: one f0 sample (unsigned Q10.8 Hz) per transfer. Samples pair up
//    into frames; the first sample after reset opens a frame.
//  - Every sample advances the phase of harmonics 1..HARMONICS by
//    f0 * h * step_per_hz (2^-48 turn units), wrapped to one turn.
//  - m_ channel: one transfer per frame, after its second sample, carrying the
//    nine harmonic phases in turns * 2^32 (fields past HARMONICS read zero).
//  - Throughput: one sample per cycle while no finished result waits, set by the
//    accumulator update in the back end. After the transfer of the frame's second
//    sample the result passes queue read with multiply, lane and accumulate.
//  - Receiver stall: the result register holds; the back end freezes and the
//    two-entry front queue absorbs samples until full, then s_ready drops.
//  - Reset (aresetn low, synchronous): accumulators clear, frame position goes
//    to first sample, step_per_hz returns to 45812984 (24 kHz sampling).
//  - APB: step_per_hz at byte address 0; write only while the block is idle.
`default_nettype none
module harmonic_phase_accumulator
    import hpa_pkg::*;
#(
    parameter int HARMONICS  = 9,
    parameter int PHASE_BITS = 32
)(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // APB config
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    // sample input
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [F0_W-1:0]   s_f0_hz,
    // phase results
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [OUT_W-1:0]       m_phase_h1,
    output logic [OUT_W-1:0]       m_phase_h2,
    output logic [OUT_W-1:0]       m_phase_h3,
    output logic [OUT_W-1:0]       m_phase_h4,
    output logic [OUT_W-1:0]       m_phase_h5,
    output logic [OUT_W-1:0]       m_phase_h6,
    output logic [OUT_W-1:0]       m_phase_h7,
    output logic [OUT_W-1:0]       m_phase_h8,
    output logic [OUT_W-1:0]       m_phase_h9
);

    logic [STEP_W-1:0]                 step_reg;
    logic                              step_hit;
    logic                              q_valid, q_ready;
    hpa_item_t                         q_item;
    logic [HARMONICS-1:0][OUT_W-1:0]   back_phase;
    logic [OUT_FIELDS-1:0][OUT_W-1:0]  phase_all;

    // register decode: word index is paddr[2]
    assign pready   = 1'b1;
    assign step_hit = (paddr[2:2] == REG_STEP_PER_HZ);
    assign prdata   = step_hit ? APB_DW'(step_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RESET;
        end else if (psel && penable && pwrite && pready && step_hit) begin
            step_reg <= pwdata[STEP_W-1:0];
        end
    end

    hpa_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_f0_hz (s_f0_hz),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    hpa_back #(
        .HARMONICS  (HARMONICS),
        .PHASE_BITS (PHASE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_per_hz (step_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_phase     (back_phase)
    );

    // unused harmonic fields read zero
    for (genvar i = 0; i < OUT_FIELDS; i++) begin : g_out
        if (i < HARMONICS) begin : g_used
            assign phase_all[i] = back_phase[i];
        end else begin : g_zero
            assign phase_all[i] = '0;
        end
    end

    assign m_phase_h1 = phase_all[0];
    assign m_phase_h2 = phase_all[1];
    assign m_phase_h3 = phase_all[2];
    assign m_phase_h4 = phase_all[3];
    assign m_phase_h5 = phase_all[4];
    assign m_phase_h6 = phase_all[5];
    assign m_phase_h7 = phase_all[6];
    assign m_phase_h8 = phase_all[7];
    assign m_phase_h9 = phase_all[8];

endmodule
`default_nettype wire

// ===== verif/hpa_checker.sv =====
// Checker for the harmonic phase accumulator: models the phase bank and compares results.
`timescale 1ns / 100ps
module hpa_checker
    import hpa_pkg::*;
#(
    parameter int HARMONICS  = 9,
    parameter int PHASE_BITS = 32
)(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    input  wire logic [APB_DW-1:0] prdata,
    input  wire logic              pready,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic [F0_W-1:0]   s_f0_hz,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire logic [OUT_W-1:0]  m_phase_h1,
    input  wire logic [OUT_W-1:0]  m_phase_h2,
    input  wire logic [OUT_W-1:0]  m_phase_h3,
    input  wire logic [OUT_W-1:0]  m_phase_h4,
    input  wire logic [OUT_W-1:0]  m_phase_h5,
    input  wire logic [OUT_W-1:0]  m_phase_h6,
    input  wire logic [OUT_W-1:0]  m_phase_h7,
    input  wire logic [OUT_W-1:0]  m_phase_h8,
    input  wire logic [OUT_W-1:0]  m_phase_h9,
    output int                     mismatch_cnt,
    output int                     frames_pending
);

    localparam logic [APB_AW-1:0] STEP_ADDR = {REG_STEP_PER_HZ, 2'b00};
    localparam logic [63:0]       ACC_MASK  = (64'd1 << PHASE_BITS) - 64'd1;

    typedef logic [OUT_FIELDS-1:0][OUT_W-1:0] phase_frame_t;

    logic [STEP_W-1:0] step_per_hz_m;
    logic [63:0]       phase_acc_m [OUT_FIELDS];
    logic              mid_frame;            // first sample of a frame taken
    phase_frame_t      frame_q [$];

    initial begin
        mismatch_cnt   = 0;
        frames_pending = 0;
    end

    // f0 * h * step in 2^-48 turn, wrapped to one turn, cut to PHASE_BITS
    function automatic logic [63:0] harmonic_increment(logic [F0_W-1:0] f0, int h,
                                                       logic [STEP_W-1:0] step);
        logic [63:0] full;
        full = 64'(f0) * 64'(h) * 64'(step);
        return {16'd0, full[FRAC_W-1:0]} >> (FRAC_W - PHASE_BITS);
    endfunction

    function automatic logic [OUT_W-1:0] to_turns32(logic [63:0] acc);
        logic [63:0] scaled;
        if (PHASE_BITS >= OUT_W) begin
            scaled = acc >> (PHASE_BITS - OUT_W);
        end else begin
            scaled = acc << (OUT_W - PHASE_BITS);
        end
        return scaled[OUT_W-1:0];
    endfunction

    task automatic advance_phases(logic [F0_W-1:0] f0);
        phase_frame_t frame;
        for (int i = 0; i < HARMONICS; i++) begin
            phase_acc_m[i] = (phase_acc_m[i] + harmonic_increment(f0, i + 1, step_per_hz_m))
                             & ACC_MASK;
        end
        if (!mid_frame) begin
            mid_frame = 1'b1;
        end else begin
            mid_frame = 1'b0;
            for (int i = 0; i < OUT_FIELDS; i++) begin
                frame[i] = (i < HARMONICS) ? to_turns32(phase_acc_m[i]) : '0;
            end
            frame_q.insert(frame_q.size(), frame);
        end
    endtask

    task automatic compare_frame(phase_frame_t got);
        phase_frame_t want;
        if (frame_q.size() == 0) begin
            mismatch_cnt++;
            $display("%0t: result transfer with no frame pending, phase_h1 %08h",
                     $time, got[0]);
        end else begin
            want = frame_q.pop_front();
            for (int i = 0; i < OUT_FIELDS; i++) begin
                if (got[i] !== want[i]) begin
                    mismatch_cnt++;
                    $display("%0t: phase_h%0d expected %08h actual %08h",
                             $time, i + 1, want[i], got[i]);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            step_per_hz_m = STEP_RESET;
            mid_frame     = 1'b0;
            for (int i = 0; i < OUT_FIELDS; i++) begin
                phase_acc_m[i] = '0;
            end
            frame_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                compare_frame({m_phase_h9, m_phase_h8, m_phase_h7, m_phase_h6, m_phase_h5,
                               m_phase_h4, m_phase_h3, m_phase_h2, m_phase_h1});
            end
            if (s_valid && s_ready) begin
                advance_phases(s_f0_hz);
            end
            // the model keeps the step at address 0 only: writes elsewhere must not touch it
            if (psel && penable && pready && paddr == STEP_ADDR) begin
                if (pwrite) begin
                    step_per_hz_m = pwdata[STEP_W-1:0];
                end else if (prdata[STEP_W-1:0] !== step_per_hz_m) begin
                    mismatch_cnt++;
                    $display("%0t: step_per_hz read expected %08h actual %08h",
                             $time, step_per_hz_m, prdata);
                end
            end
        end
        frames_pending = frame_q.size();
    end

endmodule

// ===== verif/harmonic_phase_accumulator_tb.sv =====
// Testbench top for the harmonic phase accumulator: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps
module harmonic_phase_accumulator_tb;
    import hpa_pkg::*;

    localparam int HARMONICS  = 9;
    localparam int PHASE_BITS = 32;

    localparam logic [APB_AW-1:0] STEP_ADDR  = {REG_STEP_PER_HZ, 2'b00};
    localparam logic [APB_AW-1:0] SPARE_ADDR = STEP_ADDR + APB_AW'(4);  // unmapped
    localparam logic [F0_W-1:0]   F0_MAX     = '1;

    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 238;
    localparam int HOLD_CYCLES   = 300;   // receiver hold-off, long enough to fill the block
    localparam int DRAIN_CYCLES  = 12;    // margin for a trailing sample to reach the accumulators
    localparam int STALL_LIMIT   = 2000;  // cycles without any transfer

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    logic [F0_W-1:0]   s_f0_hz;
    logic              m_valid;
    logic              m_ready;
    logic [OUT_W-1:0]  m_phase_h1, m_phase_h2, m_phase_h3, m_phase_h4, m_phase_h5;
    logic [OUT_W-1:0]  m_phase_h6, m_phase_h7, m_phase_h8, m_phase_h9;

    int   mismatch_cnt;
    int   frames_pending;
    bit   gaps_on;       // random idle cycles on both channels
    bit   hold_req;      // ask the receiver for one long hold-off
    logic [STEP_W-1:0] step_plan [RANDOM_PHASES];

    always #5 aclk = ~aclk;

    harmonic_phase_accumulator #(
        .HARMONICS  (HARMONICS),
        .PHASE_BITS (PHASE_BITS)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_f0_hz    (s_f0_hz),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_phase_h1 (m_phase_h1),
        .m_phase_h2 (m_phase_h2),
        .m_phase_h3 (m_phase_h3),
        .m_phase_h4 (m_phase_h4),
        .m_phase_h5 (m_phase_h5),
        .m_phase_h6 (m_phase_h6),
        .m_phase_h7 (m_phase_h7),
        .m_phase_h8 (m_phase_h8),
        .m_phase_h9 (m_phase_h9)
    );

    // Checker sees exactly what the block sees; it owns prediction and comparison.
    hpa_checker #(
        .HARMONICS  (HARMONICS),
        .PHASE_BITS (PHASE_BITS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_f0_hz        (s_f0_hz),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_phase_h1     (m_phase_h1),
        .m_phase_h2     (m_phase_h2),
        .m_phase_h3     (m_phase_h3),
        .m_phase_h4     (m_phase_h4),
        .m_phase_h5     (m_phase_h5),
        .m_phase_h6     (m_phase_h6),
        .m_phase_h7     (m_phase_h7),
        .m_phase_h8     (m_phase_h8),
        .m_phase_h9     (m_phase_h9),
        .mismatch_cnt   (mismatch_cnt),
        .frames_pending (frames_pending)
    );

    // ------------------------------------------------------------------
    // Drivers. Every task is entered and left at a falling edge, and each
    // signal gets one assignment per edge: a new sample rides straight on
    // the previous one, with valid dropping in between only for a random gap.
    // ------------------------------------------------------------------

    // APB write: setup cycle, then access; the register takes the data at
    // the rising edge inside the access cycle (pready is tied high).
    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // APB read: the checker compares prdata during the access cycle.
    task automatic apb_read(input logic [APB_AW-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // One f0 sample; holds valid and data until the transfer happens.
    task automatic push_f0(input logic [F0_W-1:0] f0);
        if (gaps_on && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_f0_hz <= f0;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drop valid, wait out every pending frame, then give a trailing
    // first-half sample time to land in the accumulators before any
    // register write.
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (frames_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Mix of f0 shapes: silence, the saturated maximum, tiny values,
    // voice-like pitch (50..500 Hz) and fully random words.
    function automatic logic [F0_W-1:0] pick_f0();
        case ($urandom_range(9))
            0:       return '0;
            1:       return F0_MAX;
            2:       return F0_W'($urandom_range(255));
            3, 4:    return F0_W'($urandom_range(128000, 12800));
            default: return F0_W'($urandom_range(F0_MAX));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, a clean stretch when gaps are off, and one
    // long hold-off counted here while the sender keeps offering samples.
    // ------------------------------------------------------------------
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (gaps_on) begin
                m_ready <= ($urandom_range(99) >= 9);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    initial begin
        int stall_cnt;
        stall_cnt = 0;
        while (stall_cnt < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cnt = 0;
            end else begin
                stall_cnt++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int n_items;

        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_valid  = 1'b0;
        s_f0_hz  = '0;
        gaps_on  = 1'b1;
        hold_req = 1'b0;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset value of the step register
        apb_read(STEP_ADDR);

        // Directed, reset step (24 kHz): zero frame, saturated frame, field
        // extremes and alternating bit patterns.
        push_f0('0);
        push_f0('0);
        push_f0(F0_MAX);
        push_f0(F0_MAX);
        push_f0(F0_W'(1));
        push_f0(F0_MAX - F0_W'(1));
        push_f0(F0_W'(18'h2AAAA));
        push_f0(F0_W'(18'h15555));
        push_f0(F0_W'(18'h20000));
        push_f0(F0_W'(18'h1FFFF));
        settle();

        // zero step: phases must hold whatever f0 is
        apb_write(STEP_ADDR, '0);
        apb_read(STEP_ADDR);
        push_f0(F0_MAX);
        push_f0(F0_W'(123));
        settle();

        // largest step with largest f0: full 50-bit product, heavy wrapping
        apb_write(STEP_ADDR, '1);
        apb_read(STEP_ADDR);
        push_f0(F0_MAX);
        push_f0(F0_MAX);
        push_f0(F0_W'(1));
        push_f0('0);
        settle();

        // smallest step: increments for small f0 fall below the 32-bit phase LSB
        apb_write(STEP_ADDR, APB_DW'(1));
        apb_read(STEP_ADDR);
        push_f0(F0_MAX);
        push_f0(F0_W'(1));
        settle();

        // write to an unmapped address is dropped; step must read back as 1
        apb_write(SPARE_ADDR, APB_DW'($urandom));
        apb_read(STEP_ADDR);
        push_f0(F0_MAX);
        push_f0('0);
        settle();

        // Random phases, one step setting each. Phase lengths are sometimes
        // odd so a frame can straddle a register write.
        step_plan[0] = STEP_W'($urandom);
        step_plan[1] = STEP_RESET;
        step_plan[2] = '1;
        step_plan[3] = STEP_W'(1);
        step_plan[4] = '0;
        step_plan[5] = STEP_W'($urandom);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apb_write(STEP_ADDR, APB_DW'(step_plan[p]));
            apb_read(STEP_ADDR);
            gaps_on = (p != 2);    // phase 2 runs back to back on both sides
            n_items = PHASE_ITEMS + $urandom_range(4);
            for (int n = 0; n < n_items; n++) begin
                if (p == 3 && n == 40) begin
                    hold_req = 1'b1;   // receiver stalls; input must back up
                end
                push_f0(pick_f0());
            end
            settle();
        end

        if (mismatch_cnt == 0 && frames_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
